/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock edge outside reset
`define CHK_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// condition that must never hold at a clock edge outside reset
`define CHK_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

/* hw/rtl/stap_pkg.sv */
// ----------------------------------------------------------------------------
// stap_pkg
// Types and constants of the STUN attribute TLV parser.
// ----------------------------------------------------------------------------
package stap_pkg;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       buffer_end;
	} in_item_t;

	typedef struct packed {
		logic [15:0] attr_type;
		logic [15:0] declared_length;
		logic [15:0] value_offset;
		logic [7:0]  out_byte;
		logic [1:0]  byte_kind;
		logic        attr_done;
		logic [1:0]  fault;
	} out_item_t;

	localparam logic [1:0] KIND_HDR = 2'd0;
	localparam logic [1:0] KIND_VAL = 2'd1;
	localparam logic [1:0] KIND_PAD = 2'd2;

	localparam logic [1:0] FAULT_NONE   = 2'd0;
	localparam logic [1:0] FAULT_TRUNC  = 2'd1;
	localparam logic [1:0] FAULT_FAMILY = 2'd2;

	localparam logic [2:0] CFG_COOKIE  = 3'd0;
	localparam logic [2:0] CFG_MAPPED  = 3'd1;
	localparam logic [2:0] CFG_PEER    = 3'd2;
	localparam logic [2:0] CFG_RELAYED = 3'd3;
	localparam logic [2:0] CFG_ENABLE  = 3'd4;

	localparam logic [31:0] COOKIE_RST  = 32'h2112_A442;
	localparam logic [15:0] MAPPED_RST  = 16'h0020;
	localparam logic [15:0] PEER_RST    = 16'h0012;
	localparam logic [15:0] RELAYED_RST = 16'h0016;

	localparam logic [2:0] HDR_LAST  = 3'd3;
	localparam logic [2:0] HDR_VALUE = 3'd4;

	localparam logic [7:0] FAMILY_IPV4 = 8'd1;
	localparam logic [7:0] FAMILY_IPV6 = 8'd2;

endpackage

/* hw/rtl/stun_attribute_tlv_parser_top.sv */
// ----------------------------------------------------------------------------
// stun_attribute_tlv_parser_top
// Byte-wise STUN attribute walker with XOR address decoding.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid / in_stall   | in_data  (in_item_t)
//   out     | output    | out_valid / out_stall | out_data (out_item_t)
//   cfg     | input     | cfg_we                | cfg_index, cfg_data
//
// One byte per cycle unless stalled; results come the cycle after their byte.
// The walk state and the result register update in the same cycle.
// in_stall is high only while a result is held and out_stall is high.
// Reset clears the walk state and loads the register defaults.
// ----------------------------------------------------------------------------
module stun_attribute_tlv_parser_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  stap_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output stap_pkg::out_item_t out_data,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data
);
	import stap_pkg::*;

	logic [31:0] cookie_q;
	logic [15:0] type_mapped_q;
	logic [15:0] type_peer_q;
	logic [15:0] type_relayed_q;
	logic        xor_en_q;

	logic [2:0]  hdr_cnt_q;
	logic [15:0] type_q;
	logic [15:0] len_q;
	logic [16:0] left_q;
	logic [16:0] off_q;
	logic        is_xor_q;
	logic        family_ok_q;

	logic        out_valid_q;
	out_item_t   out_data_q;

	logic        in_take;

	logic [2:0]  hdr_cnt_d;
	logic [15:0] type_d;
	logic [15:0] len_d;
	logic [16:0] left_d;
	logic [16:0] off_d;
	logic        is_xor_d;
	logic        family_ok_d;
	out_item_t   res;

	assign in_stall  = out_valid_q & out_stall;
	assign in_take   = in_valid & ~in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cookie_q       <= COOKIE_RST;
			type_mapped_q  <= MAPPED_RST;
			type_peer_q    <= PEER_RST;
			type_relayed_q <= RELAYED_RST;
			xor_en_q       <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_COOKIE:  cookie_q       <= cfg_data;
				CFG_MAPPED:  type_mapped_q  <= cfg_data[15:0];
				CFG_PEER:    type_peer_q    <= cfg_data[15:0];
				CFG_RELAYED: type_relayed_q <= cfg_data[15:0];
				CFG_ENABLE:  xor_en_q       <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		logic [7:0]  b;
		logic        end_mark;
		logic [16:0] padded;
		logic [7:0]  key;
		logic        type_hit;

		b           = in_data.in_byte;
		end_mark    = in_data.buffer_end;
		hdr_cnt_d   = hdr_cnt_q;
		type_d      = type_q;
		len_d       = len_q;
		left_d      = left_q;
		off_d       = off_q;
		is_xor_d    = is_xor_q;
		family_ok_d = family_ok_q;
		padded      = 17'd0;
		key         = 8'd0;
		type_hit    = 1'b0;

		res.attr_type       = 16'd0;
		res.declared_length = 16'd0;
		res.value_offset    = 16'd0;
		res.out_byte        = b;
		res.byte_kind       = KIND_HDR;
		res.attr_done       = 1'b0;
		res.fault           = FAULT_NONE;

		if (hdr_cnt_q < HDR_VALUE) begin
			case (hdr_cnt_q[1:0])
				2'd0:    type_d = {b, 8'd0};
				2'd1:    type_d = {type_q[15:8], b};
				2'd2:    len_d  = {b, 8'd0};
				default: len_d  = {len_q[15:8], b};
			endcase
			if (hdr_cnt_q != 3'd0)
				res.attr_type = type_d;
			if (hdr_cnt_q == HDR_LAST) begin
				res.declared_length = len_d;
				padded      = ({1'b0, len_d} + 17'd3) & 17'h1FFFC;
				left_d      = padded;
				off_d       = 17'd0;
				family_ok_d = 1'b1;
				type_hit    = (type_d == type_mapped_q) || (type_d == type_peer_q) ||
					(type_d == type_relayed_q);
				is_xor_d    = xor_en_q & type_hit;
				if (padded == 17'd0) begin
					res.attr_done = 1'b1;
					hdr_cnt_d     = 3'd0;
				end else if (end_mark) begin
					res.fault = FAULT_TRUNC;
					hdr_cnt_d = 3'd0;
				end else begin
					hdr_cnt_d = HDR_VALUE;
				end
			end else if (end_mark) begin
				hdr_cnt_d = 3'd0;
			end else begin
				hdr_cnt_d = hdr_cnt_q + 3'd1;
			end
		end else begin
			res.attr_type       = type_q;
			res.declared_length = len_q;
			res.value_offset    = off_q[15:0];
			res.byte_kind       = (off_q < {1'b0, len_q}) ? KIND_VAL : KIND_PAD;
			if (off_q == 17'd2)
				key = cookie_q[31:24];
			else if (off_q == 17'd3)
				key = cookie_q[23:16];
			else begin
				case (off_q[1:0])
					2'd0:    key = cookie_q[31:24];
					2'd1:    key = cookie_q[23:16];
					2'd2:    key = cookie_q[15:8];
					default: key = cookie_q[7:0];
				endcase
			end
			if (res.byte_kind == KIND_VAL && is_xor_q) begin
				if (off_q == 17'd1) begin
					if (b != FAMILY_IPV4 && b != FAMILY_IPV6) begin
						family_ok_d = 1'b0;
						res.fault   = FAULT_FAMILY;
					end
				end else if (off_q >= 17'd2 && family_ok_q) begin
					res.out_byte = b ^ key;
				end
			end
			left_d = left_q - 17'd1;
			off_d  = off_q + 17'd1;
			if (left_d == 17'd0) begin
				res.attr_done = 1'b1;
				hdr_cnt_d     = 3'd0;
			end else if (end_mark) begin
				res.fault = FAULT_TRUNC;
				hdr_cnt_d = 3'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_cnt_q   <= 3'd0;
			type_q      <= 16'd0;
			len_q       <= 16'd0;
			left_q      <= 17'd0;
			off_q       <= 17'd0;
			is_xor_q    <= 1'b0;
			family_ok_q <= 1'b1;
		end else if (in_take) begin
			hdr_cnt_q   <= hdr_cnt_d;
			type_q      <= type_d;
			len_q       <= len_d;
			left_q      <= left_d;
			off_q       <= off_d;
			is_xor_q    <= is_xor_d;
			family_ok_q <= family_ok_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			out_data_q <= res;
		end
	end

	`include "assert_macros.svh"

	`CHK_NEVER(a_hdr_cnt_range, hdr_cnt_q > HDR_VALUE, "header counter out of range")
	`CHK_ALWAYS(a_take_gives_result, in_take |=> out_valid_q, "accepted byte gave no result")
	`CHK_NEVER(a_trunc_not_done,
		out_valid_q && out_data_q.fault == FAULT_TRUNC && out_data_q.attr_done,
		"truncated attribute marked done")
	`CHK_NEVER(a_hdr_no_offset,
		out_valid_q && out_data_q.byte_kind == KIND_HDR && out_data_q.value_offset != 16'd0,
		"header byte with nonzero offset")

endmodule
